FILE: design/touch_press_backlight_latch_macros.svh
// assertion macros shared by the backlight latch checker
`ifndef TOUCH_PRESS_BACKLIGHT_LATCH_MACROS_SVH
`define TOUCH_PRESS_BACKLIGHT_LATCH_MACROS_SVH

// antecedent holds, consequent must hold on the next clock
`define TPBL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// antecedent holds, consequent must hold on the same clock
`define TPBL_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`endif

FILE: design/tpbl_pkg.sv
// shared types and constants of the touch press backlight latch
package tpbl_pkg;

	// fixed register widths
	localparam int MS16_W = 16;
	localparam int STEP_W = 8;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 16;
	localparam int TDATA_W = 8;

	localparam int TIMER_BITS_DEF = 16;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_LATCH      = 3'd1;
	localparam logic [IDX_W-1:0] REG_BLINK_DLY  = 3'd2;
	localparam logic [IDX_W-1:0] REG_BLINK_STEP = 3'd3;
	localparam logic [IDX_W-1:0] REG_POLL       = 3'd4;

	// register reset values
	localparam logic [MS16_W-1:0] DEBOUNCE_RST   = 16'd100;
	localparam logic [MS16_W-1:0] LATCH_RST      = 16'd5000;
	localparam logic [MS16_W-1:0] BLINK_DLY_RST  = 16'd100;
	localparam logic [STEP_W-1:0] BLINK_STEP_RST = 8'd6;
	localparam logic [STEP_W-1:0] POLL_RST       = 8'd20;

	typedef enum logic [2:0] {
		PH_REST    = 3'd0,
		PH_IRQ     = 3'd1,
		PH_UNFIRED = 3'd2,
		PH_BLINK   = 3'd3,
		PH_FIRED   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [MS16_W-1:0] short_min;
		logic [MS16_W-1:0] latch_ms;
		logic [MS16_W-1:0] toggle_gap;
		logic [STEP_W-1:0] toggle_total;
		logic [STEP_W-1:0] eval_period;
	} cfg_t;

endpackage

FILE: design/tpbl_core.sv
// press state machine with its timers and the light and latch result bits
module tpbl_core #(
	parameter int TIMER_BITS = tpbl_pkg::TIMER_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  tpbl_pkg::cfg_t cfg,
	input  logic          touch_pressed,
	input  logic          press_edge,
	input  logic          radio_busy,
	output logic          backlight_on,
	output logic          latched
);
	import tpbl_pkg::*;

	localparam int CMP_W = (TIMER_BITS > MS16_W) ? TIMER_BITS : MS16_W;

	phase_t phase_q, phase_d;
	logic [TIMER_BITS-1:0] press_q, press_d, press_inc;
	logic [TIMER_BITS-1:0] blink_q, blink_d, blink_inc;
	logic [STEP_W-1:0]     bcnt_q, bcnt_d, bcnt_inc;
	logic [STEP_W-1:0]     poll_q, poll_d, poll_inc;
	logic                  light_q, light_d;
	logic                  latch_q, latch_d;
	logic [CMP_W-1:0]      press_x, blink_x, debounce_x, latch_x, delay_x;

	// saturating and wrapping increments
	always_comb begin
		press_inc = (press_q == {TIMER_BITS{1'b1}}) ? press_q : press_q + 1'b1;
		blink_inc = (blink_q == {TIMER_BITS{1'b1}}) ? blink_q : blink_q + 1'b1;
		poll_inc  = poll_q + 1'b1;
		bcnt_inc  = bcnt_q + 1'b1;
		press_x    = CMP_W'(press_inc);
		blink_x    = CMP_W'(blink_inc);
		debounce_x = CMP_W'(cfg.short_min);
		latch_x    = CMP_W'(cfg.latch_ms);
		delay_x    = CMP_W'(cfg.toggle_gap);
	end

	// next state for one tick
	always_comb begin
		phase_d = phase_q;
		press_d = press_q;
		blink_d = blink_q;
		bcnt_d  = bcnt_q;
		poll_d  = poll_q;
		light_d = light_q;
		latch_d = latch_q;
		if (phase_q == PH_REST) begin
			if (press_edge) begin
				phase_d = PH_IRQ;
				press_d = '0;
				poll_d  = '0;
			end
		end else begin
			press_d = press_inc;
			blink_d = blink_inc;
			poll_d  = poll_inc;
			// one evaluation per poll interval
			if (poll_inc >= cfg.eval_period) begin
				poll_d = '0;
				case (phase_q)
					PH_IRQ: begin
						if (radio_busy) begin
							phase_d = PH_REST;
						end else begin
							light_d = 1'b1;
							latch_d = 1'b0;
							phase_d = PH_UNFIRED;
						end
					end
					PH_UNFIRED: begin
						if (!touch_pressed) begin
							phase_d = PH_REST;
							if (press_x > debounce_x && press_x < latch_x) begin
								light_d = 1'b0;
								latch_d = 1'b0;
							end
						end else if (press_x >= latch_x) begin
							phase_d = PH_BLINK;
							blink_d = '0;
							bcnt_d  = '0;
							light_d = 1'b0;
						end
					end
					PH_BLINK: begin
						if (blink_x >= delay_x) begin
							bcnt_d  = bcnt_inc;
							blink_d = '0;
							light_d = bcnt_inc[0];
							if (bcnt_inc == cfg.toggle_total) begin
								latch_d = 1'b1;
								phase_d = PH_FIRED;
							end
						end
					end
					PH_FIRED: begin
						if (!touch_pressed) begin
							phase_d = PH_REST;
						end
					end
					default: begin
						phase_d = PH_REST;
					end
				endcase
			end
		end
	end

	// state registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_REST;
			press_q <= '0;
			blink_q <= '0;
			bcnt_q  <= '0;
			poll_q  <= '0;
			light_q <= 1'b0;
			latch_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			press_q <= press_d;
			blink_q <= blink_d;
			bcnt_q  <= bcnt_d;
			poll_q  <= poll_d;
			light_q <= light_d;
			latch_q <= latch_d;
		end
	end

	assign backlight_on = light_q;
	assign latched      = latch_q;

endmodule

FILE: design/touch_press_backlight_latch.sv
// top level of the touch press backlight latch controller
//
// channel  | direction | tdata bits (lowest first)
// s_*      | in        | touch_pressed, press_edge, radio_busy, zero fill
// m_*      | out       | backlight_on, latched, zero fill
// cfg_*    | in        | write only, index 0..4, 16-bit data
//
// one tick per cycle while s_tready is high: the state and result bits update at the edge that accepts a tick
// the light and latch flops are the result register, m_tvalid marks it pending
// a tick is taken while the result is empty or being taken in the same cycle
// reset clears the state machine, timers, result and loads register defaults
module touch_press_backlight_latch #(
	parameter int TIMER_BITS = tpbl_pkg::TIMER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tpbl_pkg::TDATA_W-1:0] s_tdata,  // touch_pressed, press_edge, radio_busy
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tpbl_pkg::TDATA_W-1:0] m_tdata,  // backlight_on, latched
	input  logic                          cfg_wen,
	input  logic [tpbl_pkg::IDX_W-1:0]   cfg_index,
	input  logic [tpbl_pkg::DATA_W-1:0]  cfg_wdata
);
	import tpbl_pkg::*;

	cfg_t cfg_q;
	logic m_valid_q;
	logic step;
	logic light_on, latch_on;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min    <= DEBOUNCE_RST;
			cfg_q.latch_ms     <= LATCH_RST;
			cfg_q.toggle_gap   <= BLINK_DLY_RST;
			cfg_q.toggle_total <= BLINK_STEP_RST;
			cfg_q.eval_period  <= POLL_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_DEBOUNCE:   cfg_q.short_min    <= cfg_wdata;
				REG_LATCH:      cfg_q.latch_ms     <= cfg_wdata;
				REG_BLINK_DLY:  cfg_q.toggle_gap   <= cfg_wdata;
				REG_BLINK_STEP: cfg_q.toggle_total <= cfg_wdata[STEP_W-1:0];
				REG_POLL:       cfg_q.eval_period  <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// input handshake
	assign s_tready = !m_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	// result pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	tpbl_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.cfg          (cfg_q),
		.touch_pressed(s_tdata[0]),
		.press_edge   (s_tdata[1]),
		.radio_busy   (s_tdata[2]),
		.backlight_on (light_on),
		.latched      (latch_on)
	);

	// result transfer
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(TDATA_W-2){1'b0}}, latch_on, light_on};

endmodule

FILE: design/tpbl_chk.sv
// port-level checker for the backlight latch, bound to the top level
`include "touch_press_backlight_latch_macros.svh"

module tpbl_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);
	// a stalled result stays offered
	`TPBL_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	// every accepted tick leaves a result next cycle
	`TPBL_ASSERT_NEXT(a_tick_result, s_tvalid && s_tready, m_tvalid)
	// an empty result slot never blocks the input
	`TPBL_ASSERT_SAME(a_ready_empty, !m_tvalid, s_tready)
	// result bits change only after an accepted tick
	`TPBL_ASSERT_NEXT(a_bits_idle, !(s_tvalid && s_tready), $stable(m_tdata[1:0]))
	// pad bits stay zero
	`TPBL_ASSERT_SAME(a_pad_zero, 1'b1, m_tdata[7:2] == 6'd0)

endmodule

bind touch_press_backlight_latch tpbl_chk u_tpbl_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the touch press backlight latch
module tb;
	import tpbl_pkg::*;

	localparam int TIMER_W    = TIMER_BITS_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_OFF   = 400;
	localparam int PRESSURE_AT = 200;

	typedef struct packed {
		logic backlight_on;
		logic latched;
	} light_t;

	typedef struct packed {
		logic touch_pressed;
		logic press_edge;
		logic radio_busy;
		logic typed;
		logic backlight_on;
		logic latched;
	} tick_row_t;

	typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY} sink_mode_t;

	// directed ticks under a short-timer setting: drop on busy radio, peek,
	// short press under debounce, debounced release, ignored edges, blink and latch
	localparam tick_row_t DIRECTED_ROWS [0:24] = '{
		'{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
		'{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
		'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}
	};

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;  // touch_pressed, press_edge, radio_busy
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;  // backlight_on, latched
	logic               cfg_wen;
	logic [IDX_W-1:0]   cfg_index;
	logic [DATA_W-1:0]  cfg_wdata;

	// shadow of the controller state
	cfg_t               regs;
	phase_t             ph;
	logic [TIMER_W-1:0] press_ms;
	logic [TIMER_W-1:0] blink_ms;
	logic [STEP_W-1:0]  blink_cnt;
	logic [STEP_W-1:0]  poll_cnt;
	logic               light;
	logic               latch;

	light_t light_q[$];
	int     fail_count  = 0;
	int     results_seen = 0;
	int     burst_left  = 0;

	touch_press_backlight_latch DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit coin(input int one_in);
		return $urandom_range(0, one_in - 1) == 0;
	endfunction

	function automatic cfg_t make_regs(input int unsigned deb, input int unsigned lat,
			input int unsigned dly, input int unsigned steps, input int unsigned poll);
		cfg_t r;
		r.short_min    = deb[MS16_W-1:0];
		r.latch_ms     = lat[MS16_W-1:0];
		r.toggle_gap   = dly[MS16_W-1:0];
		r.toggle_total = steps[STEP_W-1:0];
		r.eval_period  = poll[STEP_W-1:0];
		return r;
	endfunction

	// one millisecond tick of the controller, returns the light and latch after it
	task automatic step_light(input logic touch, input logic pedge, input logic busy,
			output light_t res);
		if (ph == PH_REST) begin
			if (pedge) begin
				ph       = PH_IRQ;
				press_ms = '0;
				poll_cnt = '0;
			end
		end else begin
			if (press_ms != '1) press_ms = press_ms + 1'b1;
			if (blink_ms != '1) blink_ms = blink_ms + 1'b1;
			poll_cnt = poll_cnt + 1'b1;
			if (poll_cnt >= regs.eval_period) begin
				poll_cnt = '0;
				case (ph)
					PH_IRQ: begin
						if (busy) begin
							ph = PH_REST;
						end else begin
							light = 1'b1;
							latch = 1'b0;
							ph    = PH_UNFIRED;
						end
					end
					PH_UNFIRED: begin
						if (!touch) begin
							ph = PH_REST;
							// released between debounce and latch time
							if (press_ms > regs.short_min && press_ms < regs.latch_ms) begin
								light = 1'b0;
								latch = 1'b0;
							end
						end else if (press_ms >= regs.latch_ms) begin
							ph        = PH_BLINK;
							blink_ms  = '0;
							blink_cnt = '0;
							light     = 1'b0;
						end
					end
					PH_BLINK: begin
						if (blink_ms >= regs.toggle_gap) begin
							blink_cnt = blink_cnt + 1'b1;
							blink_ms  = '0;
							light     = blink_cnt[0];
							if (blink_cnt == regs.toggle_total) begin
								latch = 1'b1;
								ph    = PH_FIRED;
							end
						end
					end
					PH_FIRED: begin
						if (!touch) ph = PH_REST;
					end
					default: ph = PH_REST;
				endcase
			end
		end
		res.backlight_on = light;
		res.latched      = latch;
	endtask

	// offer one tick in bursts with random gaps, record its expected light
	task automatic send_tick(input logic touch, input logic pedge, input logic busy,
			input logic typed, input light_t typed_res);
		light_t res;
		int     gap;
		if (burst_left == 0) begin
			gap = coin(4) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = coin(8) ? $urandom_range(100, 400) : $urandom_range(1, 30);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(TDATA_W-3){1'b0}}, busy, pedge, touch};
		do @(posedge clk); while (!s_tready);
		step_light(touch, pedge, busy, res);
		light_q.push_back(typed ? typed_res : res);
	endtask

	task automatic send_plain(input logic touch, input logic pedge, input logic busy);
		send_tick(touch, pedge, busy, 1'b0, '0);
	endtask

	// stop offering and let every expected transfer drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (light_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic write_regs(input cfg_t v);
		regs = v;
		put_reg(REG_DEBOUNCE, v.short_min);
		put_reg(REG_LATCH, v.latch_ms);
		put_reg(REG_BLINK_DLY, v.toggle_gap);
		put_reg(REG_BLINK_STEP, {{(DATA_W-STEP_W){1'b0}}, v.toggle_total});
		put_reg(REG_POLL, {{(DATA_W-STEP_W){1'b0}}, v.eval_period});
		cfg_wen <= 1'b0;
	endtask

	// mostly whole presses with random content, some noise and cut-short presses
	task automatic run_presses(input int n, input int hold_max);
		int sent;
		int len;
		int rel;
		int rel_max;
		int kind;
		sent    = 0;
		rel_max = 2 * int'(regs.eval_period) + 3;
		// keep releases short under long poll intervals
		if (rel_max > 40) rel_max = 40;
		while (sent < n) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				len = $urandom_range(1, 8);
				repeat (len) send_plain(coin(2), coin(2), coin(2));
			end else begin
				len = (kind == 2) ? $urandom_range(0, 3) : $urandom_range(0, hold_max);
				send_plain(1'b1, 1'b1, coin(6));
				repeat (len) send_plain(1'b1, coin(2), coin(4));
				rel = $urandom_range(1, rel_max);
				repeat (rel) send_plain(1'b0, coin(8), coin(2));
				len += rel + 1;
			end
			sent += len;
		end
	endtask

	// result checker
	always @(posedge clk) begin : check_light
		light_t want;
		light_t got;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got.backlight_on = m_tdata[0];
			got.latched      = m_tdata[1];
			if (light_q.size() == 0) begin
				$error("result transfer with no tick waiting: backlight_on %0b latched %0b",
					got.backlight_on, got.latched);
				fail_count++;
			end else begin
				want = light_q.pop_front();
				if (got.backlight_on !== want.backlight_on) begin
					$error("backlight_on mismatch: expected %0b, got %0b",
						want.backlight_on, got.backlight_on);
					fail_count++;
				end
				if (got.latched !== want.latched) begin
					$error("latched mismatch: expected %0b, got %0b",
						want.latched, got.latched);
					fail_count++;
				end
			end
		end
	end

	// receiver: changing stall pattern, one long hold-off to back up the input
	initial begin : sink
		sink_mode_t mode;
		int         mode_left;
		bit         held_off;
		mode      = SINK_OPEN;
		mode_left = 0;
		held_off  = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= PRESSURE_AT) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode      = sink_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			case (mode)
				SINK_OPEN:  m_tready <= 1'b1;
				SINK_LIGHT: m_tready <= !coin(4);
				default:    m_tready <= coin(3);
			endcase
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// main sequence
	initial begin : stimulus
		tick_row_t row;
		light_t    row_res;
		arst_n     = 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_wen   <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		regs.short_min    = DEBOUNCE_RST;
		regs.latch_ms     = LATCH_RST;
		regs.toggle_gap   = BLINK_DLY_RST;
		regs.toggle_total = BLINK_STEP_RST;
		regs.eval_period  = POLL_RST;
		ph        = PH_REST;
		press_ms  = '0;
		blink_ms  = '0;
		blink_cnt = '0;
		poll_cnt  = '0;
		light     = 1'b0;
		latch     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under short timers
		write_regs(make_regs(2, 6, 1, 2, 1));
		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			row_res.backlight_on = row.backlight_on;
			row_res.latched      = row.latched;
			send_tick(row.touch_pressed, row.press_edge, row.radio_busy, row.typed, row_res);
		end
		settle();

		// long hold: blink count wraps before latching
		write_regs(make_regs(2, 4, 1, 0, 1));
		send_plain(1'b1, 1'b1, 1'b0);
		send_plain(1'b1, 1'b0, 1'b0);
		repeat (270) send_plain(1'b1, coin(2), coin(2));
		repeat (3) send_plain(1'b0, 1'b0, coin(2));
		settle();

		// random presses over several settings
		write_regs(make_regs(3, 20, 2, 3, 2));
		run_presses(100, 60);
		settle();
		// zero latch time, zero poll interval
		write_regs(make_regs(0, 0, 1, 1, 0));
		run_presses(80, 15);
		settle();
		// every register at its top value
		write_regs(make_regs(65535, 65535, 65535, 255, 255));
		run_presses(130, 100);
		settle();
		write_regs(make_regs($urandom_range(0, 20), $urandom_range(1, 40),
			$urandom_range(1, 5), $urandom_range(1, 8), $urandom_range(1, 4)));
		run_presses(80, 60);
		settle();
		write_regs(make_regs($urandom_range(0, 20), $urandom_range(1, 40),
			$urandom_range(1, 5), $urandom_range(1, 8), $urandom_range(1, 4)));
		run_presses(80, 60);
		settle();

		repeat (8) @(posedge clk);
		if (fail_count == 0 && light_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
